// ===== sv/linear_probing_hash_map_assert.svh =====
// ----------------------------------------------------------------------------
// linear_probing_hash_map assertion macros
// clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBING_HASH_MAP_ASSERT_SVH
`define LINEAR_PROBING_HASH_MAP_ASSERT_SVH

// same-cycle implication
`define LPHM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lphm assertion failed");

// next-cycle implication
`define LPHM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lphm assertion failed");

`endif

// ===== sv/lphm_pkg.sv =====
// ----------------------------------------------------------------------------
// lphm_pkg
// types and constants shared by the linear probing hash map
// ----------------------------------------------------------------------------
package lphm_pkg;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [63:0] HASH_MULT = 64'h9e37_79b9_7f4a_7c15;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] key;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        hit;
        logic        table_full;
    } out_item_t;

    typedef struct packed {
        logic        used;
        logic [63:0] key;
        logic [31:0] value;
    } entry_t;

endpackage

// ===== sv/lphm_ram.sv =====
// ----------------------------------------------------------------------------
// lphm_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/lphm_hash.sv =====
// ----------------------------------------------------------------------------
// lphm_hash
// fibonacci hash: low 64 bits of key * constant from one shared 32x32
// multiplier over three passes, home slot is the top index bits
// ----------------------------------------------------------------------------
module lphm_hash
    import lphm_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [63:0]              key,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] home
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = $clog2(SLOTS + 1) - 1;

    typedef enum logic [5:0] {
        H_IDLE = 6'b000001,
        H_MUL0 = 6'b000010,
        H_MUL1 = 6'b000100,
        H_MUL2 = 6'b001000,
        H_ADD  = 6'b010000,
        H_DONE = 6'b100000
    } hstate_t;

    hstate_t     state_reg, state_next;
    logic [63:0] key_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mul_a, mul_b;

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        mul_a      = key_reg[31:0];
        mul_b      = HASH_MULT[31:0];
        unique case (state_reg)
            H_IDLE: begin
                if (start) begin
                    state_next = H_MUL0;
                end
            end
            H_MUL0: begin
                state_next = H_MUL1;
            end
            H_MUL1: begin
                mul_a      = key_reg[63:32];
                acc_next   = prod_reg;
                state_next = H_MUL2;
            end
            H_MUL2: begin
                mul_b      = HASH_MULT[63:32];
                acc_next   = acc_reg + {prod_reg[31:0], 32'd0};
                state_next = H_ADD;
            end
            H_ADD: begin
                acc_next   = acc_reg + {prod_reg[31:0], 32'd0};
                state_next = H_DONE;
            end
            H_DONE: begin
                state_next = H_IDLE;
            end
            default: begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == H_IDLE && start) begin
            key_reg <= key;
        end
        prod_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        acc_reg  <= acc_next;
    end

    assign done = (state_reg == H_DONE);
    assign home = SLOT_W'(acc_reg[63 -: IDX_W]);

endmodule

// ===== sv/linear_probing_hash_map.sv =====
// ----------------------------------------------------------------------------
// linear_probing_hash_map
// open-addressing key/value map with linear probing and fibonacci hashing
//
//   channel  ports       direction  payload
//   input    s_valid/s_  in         in_item_t  (command, key, value)
//   result   m_valid/m_  out        out_item_t (result_value, hit, table_full)
//
// lookup/insert: accept, hash, per probe a ram read and compare, then the result
// clear: one ram entry per cycle; a full insert or command 3 skips to the result
// after reset a clearing pass over all slots runs with s_ready low
// one item at a time; the result register lets the next item start while a
// result waits, the block stalls only to hand over a new result
// ----------------------------------------------------------------------------
module linear_probing_hash_map
    import lphm_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

`include "linear_probing_hash_map_assert.svh"

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ENT_W  = $bits(entry_t);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_HASH  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_CHECK = 6'b001000,
        ST_CLEAR = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [63:0]       key_reg, key_next;
    logic [31:0]       value_reg, value_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  probe_reg, probe_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic              report_reg, report_next;
    out_item_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              accept;
    logic              table_is_full;
    logic              hash_start, hash_done;
    logic [SLOT_W-1:0] hash_home;
    logic [SLOT_W-1:0] slot_inc;
    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;
    entry_t            rd_entry;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign table_is_full = (count_reg >= CNT_W'(SLOTS));
    assign hash_start    = accept && ((s_data.command == CMD_LOOKUP) ||
                           (s_data.command == CMD_INSERT && !table_is_full));
    assign slot_inc      = (slot_reg == SLOT_W'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;
    assign rd_entry      = entry_t'(ram_rdata);

    lphm_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (s_data.key),
        .done    (hash_done),
        .home    (hash_home)
    );

    lphm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        value_next   = value_reg;
        slot_next    = slot_reg;
        probe_next   = probe_reg;
        count_next   = count_reg;
        clr_next     = clr_reg;
        report_next  = report_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = slot_reg;
        ram_wdata    = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next   = s_data.command;
                    key_next   = s_data.key;
                    value_next = s_data.value;
                    probe_next = '0;
                    res_next   = '0;
                    case (s_data.command)
                        CMD_LOOKUP: begin
                            state_next = ST_HASH;
                        end
                        CMD_INSERT: begin
                            if (table_is_full) begin
                                res_next.table_full = 1'b1;
                                state_next          = ST_DONE;
                            end else begin
                                state_next = ST_HASH;
                            end
                        end
                        CMD_CLEAR: begin
                            clr_next    = '0;
                            report_next = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    slot_next  = hash_home;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!rd_entry.used) begin
                    if (cmd_reg == CMD_INSERT) begin
                        ram_we     = 1'b1;
                        ram_wdata  = '{used: 1'b1, key: key_reg, value: value_reg};
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_DONE;
                end else if (cmd_reg == CMD_LOOKUP && rd_entry.key == key_reg) begin
                    res_next.result_value = rd_entry.value;
                    res_next.hit          = 1'b1;
                    state_next            = ST_DONE;
                end else if (probe_reg == CNT_W'(SLOTS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    probe_next = probe_reg + 1'b1;
                    slot_next  = slot_inc;
                    state_next = ST_READ;
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == SLOT_W'(SLOTS - 1)) begin
                    count_next = '0;
                    state_next = report_reg ? ST_DONE : ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            report_reg  <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            report_reg  <= report_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        slot_reg   <= slot_next;
        probe_reg  <= probe_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `LPHM_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(SLOTS))
    `LPHM_ASSERT_IMP(a_write_is_insert, ram_we && state_reg == ST_CHECK, cmd_reg == CMD_INSERT)
    `LPHM_ASSERT_NXT(a_insert_count, ram_we && state_reg == ST_CHECK, count_reg == $past(count_reg) + 1'b1)
    `LPHM_ASSERT_NXT(a_clear_sweep, accept && s_data.command == CMD_CLEAR, state_reg == ST_CLEAR && clr_reg == '0)

endmodule

// ===== test/linear_probing_hash_map_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probing_hash_map_tb
// self-checking bench for the linear probing hash map: a queue of pending
// items feeds a valid/ready driver, each accepted item runs through a local
// map model, and the monitor checks every result against the prediction
// kept for that item, with random idling on both channels
// ----------------------------------------------------------------------------
module linear_probing_hash_map_tb;
    import lphm_pkg::*;

    localparam int SLOTS     = 256;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int TAIL_ITEMS = 40;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 100;

    typedef logic [SLOT_BITS-1:0] slot_t;

    typedef struct {
        in_item_t item;
        bit       drain;
    } pending_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    pending_t  pending[$];
    out_item_t predicted_results[int];
    int        accepted_count = 0;
    int        received_count = 0;
    int        total_items = 0;
    int        mismatch_count = 0;
    int        gap_left = 0;
    int        ready_left = 0;

    // map model
    bit          model_used[SLOTS];
    logic [63:0] model_key[SLOTS];
    logic [31:0] model_value[SLOTS];
    int          model_count = 0;

    // stimulus-side view of the map
    logic [63:0] stim_keys[$];
    int          stim_count = 0;

    linear_probing_hash_map #(
        .SLOTS(SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic slot_t fib_home(logic [63:0] key);
        logic [63:0] prod;
        prod = key * HASH_MULT;
        return slot_t'(prod >> (64 - SLOT_BITS));
    endfunction

    function automatic out_item_t hash_map_step(in_item_t it);
        out_item_t res;
        slot_t     idx;
        res = '0;
        idx = fib_home(it.key);
        case (it.command)
            CMD_LOOKUP: begin
                for (int probe = 0; probe < SLOTS; probe++) begin
                    if (!model_used[idx]) break;
                    if (model_key[idx] == it.key) begin
                        res.result_value = model_value[idx];
                        res.hit = 1'b1;
                        break;
                    end
                    idx = slot_t'((idx + 1) % SLOTS);
                end
            end
            CMD_INSERT: begin
                if (model_count >= SLOTS) begin
                    res.table_full = 1'b1;
                end else begin
                    while (model_used[idx]) idx = slot_t'((idx + 1) % SLOTS);
                    model_used[idx] = 1'b1;
                    model_key[idx] = it.key;
                    model_value[idx] = it.value;
                    model_count++;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) model_used[i] = 1'b0;
                model_count = 0;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [63:0] random_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] key_at_home(slot_t h);
        logic [63:0] k;
        k = random_key();
        while (fib_home(k) != h) k = random_key();
        return k;
    endfunction

    function automatic logic [63:0] pool_key();
        return stim_keys[$urandom_range(0, stim_keys.size() - 1)];
    endfunction

    task automatic push_item(logic [1:0] cmd, logic [63:0] key, logic [31:0] value,
                             bit drain = 1'b0);
        pending_t p;
        p.item.command = cmd;
        p.item.key = key;
        p.item.value = value;
        p.drain = drain;
        pending.push_back(p);
        if (cmd == CMD_INSERT && stim_count < SLOTS) begin
            stim_count++;
            stim_keys.push_back(key);
        end else if (cmd == CMD_CLEAR) begin
            stim_count = 0;
            stim_keys.delete();
        end
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t item %0d %s: got %h, want %h", $time, received_count, field, got, want);
        mismatch_count++;
    endtask

    function automatic bit in_tail();
        return accepted_count + TAIL_ITEMS >= total_items;
    endfunction

    // driver
    always @(posedge aclk) begin
        bit sent;
        sent = s_valid && s_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (sent) begin
                predicted_results[accepted_count] = hash_map_step(s_data);
                accepted_count <= accepted_count + 1;
                if (!in_tail() && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 13);
            end
            if (!s_valid || sent) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending.size() > 0 &&
                             (!pending[0].drain ||
                              (!sent && accepted_count == received_count))) begin
                    s_data <= pending[0].item;
                    s_valid <= 1'b1;
                    void'(pending.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (received_count >= accepted_count) begin
                    report_mismatch("unexpected item", m_data.result_value, 32'd0);
                end else begin
                    want = predicted_results[received_count];
                    if (m_data.result_value !== want.result_value)
                        report_mismatch("result_value", m_data.result_value, want.result_value);
                    if (m_data.hit !== want.hit)
                        report_mismatch("hit", 32'(m_data.hit), 32'(want.hit));
                    if (m_data.table_full !== want.table_full)
                        report_mismatch("table_full", 32'(m_data.table_full),
                                        32'(want.table_full));
                    predicted_results.delete(received_count);
                    received_count <= received_count + 1;
                end
            end
            if (ready_left > 0) begin
                ready_left--;
            end else if (in_tail() || $urandom_range(0, 1) == 1) begin
                m_ready <= 1'b1;
                ready_left = in_tail() ? 0 : $urandom_range(1, 20);
            end else begin
                m_ready <= 1'b0;
                ready_left = $urandom_range(0, 12);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("linear_probing_hash_map: mismatch");
        $finish;
    end

    initial begin
        logic [63:0] k0, k1, k2, k3;
        logic [63:0] ones;
        int r;
        ones = '1;

        // directed: extremes, duplicates, ignored command, collisions, wrap
        push_item(CMD_LOOKUP, 64'd0, $urandom);
        push_item(CMD_INSERT, 64'd0, 32'd0);
        push_item(CMD_INSERT, ones, 32'hffff_ffff);
        push_item(CMD_LOOKUP, 64'd0, $urandom);
        push_item(CMD_LOOKUP, ones, $urandom);
        push_item(CMD_INSERT, 64'd0, 32'h1234_5678);
        push_item(CMD_LOOKUP, 64'd0, 32'hffff_ffff);
        push_item(CMD_UNUSED, ones, 32'hffff_ffff);
        push_item(CMD_UNUSED, 64'd0, 32'd0);
        push_item(CMD_LOOKUP, ones, 32'd0);
        k0 = key_at_home(slot_t'(SLOTS / 2));
        k1 = key_at_home(slot_t'(SLOTS / 2));
        k2 = key_at_home(slot_t'(SLOTS / 2));
        k3 = key_at_home(slot_t'(SLOTS / 2));
        push_item(CMD_INSERT, k0, $urandom);
        push_item(CMD_INSERT, k1, $urandom);
        push_item(CMD_INSERT, k2, $urandom);
        push_item(CMD_LOOKUP, k2, $urandom);
        push_item(CMD_LOOKUP, k3, $urandom);
        k0 = key_at_home(slot_t'(SLOTS - 1));
        k1 = key_at_home(slot_t'(SLOTS - 1));
        push_item(CMD_INSERT, k0, $urandom);
        push_item(CMD_INSERT, k1, $urandom);
        push_item(CMD_LOOKUP, k1, $urandom);
        push_item(CMD_CLEAR, ones, $urandom, 1'b1);
        push_item(CMD_LOOKUP, 64'd0, $urandom);
        push_item(CMD_LOOKUP, k1, $urandom);

        // fill the table to the brim, then overflow and probe it
        while (stim_count < SLOTS) begin
            r = $urandom_range(0, 99);
            if (r < 75)
                push_item(CMD_INSERT, ($urandom_range(0, 9) == 0 && stim_keys.size() > 0) ?
                          pool_key() : random_key(), $urandom);
            else if (r < 95 && stim_keys.size() > 0)
                push_item(CMD_LOOKUP, pool_key(), $urandom);
            else
                push_item(CMD_UNUSED, random_key(), $urandom);
        end
        for (int i = 0; i < 4; i++) push_item(CMD_INSERT, random_key(), $urandom);
        for (int i = 0; i < 12; i++)
            push_item(CMD_LOOKUP, (i % 2 == 0) ? pool_key() : random_key(), $urandom);
        push_item(CMD_CLEAR, random_key(), $urandom);

        // low-load rounds, each starting once the block has gone idle
        for (int round = 0; round < 6; round++) begin
            for (int i = 0; i < 40; i++) begin
                r = $urandom_range(0, 99);
                if (stim_count >= 120) begin
                    push_item(CMD_CLEAR, random_key(), $urandom, i == 0);
                end else if (r < 45) begin
                    if (stim_keys.size() > 0 && $urandom_range(0, 9) < 7)
                        k0 = pool_key();
                    else if (stim_keys.size() > 0 && $urandom_range(0, 1) == 1)
                        k0 = key_at_home(fib_home(pool_key()));
                    else
                        k0 = random_key();
                    push_item(CMD_LOOKUP, k0, $urandom, i == 0);
                end else if (r < 85) begin
                    if (stim_keys.size() > 0 && $urandom_range(0, 99) < 15)
                        k0 = pool_key();
                    else if (stim_keys.size() > 0 && $urandom_range(0, 99) < 25)
                        k0 = key_at_home(fib_home(pool_key()));
                    else
                        k0 = random_key();
                    push_item(CMD_INSERT, k0, $urandom, i == 0);
                end else if (r < 92) begin
                    push_item(CMD_UNUSED, random_key(), $urandom, i == 0);
                end else if (r < 96) begin
                    push_item(CMD_CLEAR, random_key(), $urandom, i == 0);
                end else begin
                    push_item(CMD_LOOKUP, random_key(), $urandom, i == 0);
                end
            end
        end

        total_items = pending.size();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() > 0 || s_valid) @(posedge aclk);
        while (received_count != accepted_count) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("linear_probing_hash_map: match");
        end else begin
            $display("linear_probing_hash_map: mismatch");
        end
        $finish;
    end

endmodule
